/* hw/rtl/rpn_stack_calculator_defines.svh */
// Assertion macros used by the rpn_checker file.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH
// Assert a property sampled on the rising clock, disabled during reset.
`define RPN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that a signal is never unknown out of reset.
`define RPN_KNOWN(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) else $error(msg);
`endif

/* hw/rtl/rpn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int StackDepth = 16;
    localparam int PtrW       = $clog2(StackDepth);
    localparam int CntW       = $clog2(StackDepth + 1);

    typedef enum logic [3:0] {
        K_PUSH = 4'd0, K_ADD = 4'd1, K_SUB = 4'd2, K_MUL = 4'd3, K_DIV = 4'd4,
        K_NEG = 4'd5, K_DUP = 4'd6, K_SWAP = 4'd7, K_CLEAR = 4'd8,
        K_PALL = 4'd9, K_PTOP = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_FEW = 2'd1, ST_DIVZERO = 2'd2, ST_FULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               has_value;
        logic signed [31:0] value_res;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_WR1, S_WR2, S_PRD, S_PEMIT, S_EMIT
    } state_t;

    // Datapath operation selected by the controller
    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_NEG, OP_PASS
    } alu_op_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic            rd_en;
        logic [PtrW-1:0] rd_addr;
        logic            load_a;     // capture read data as top
        logic            load_b;     // capture read data as second
        logic            load_cmd;   // capture push value into a
        logic            wr_en;
        logic [PtrW-1:0] wr_addr;
        logic            wr_sel_b;   // write b instead of result
        logic            alu_go;     // register alu result
        alu_op_t         op;
        logic            div_start;
        logic            out_load;
        logic [1:0]      out_status;
        logic            out_has;
        logic            out_last;
        logic            out_from_rd; // print uses read data
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic a_zero;
        logic out_full;
    } stat_t;

endpackage

/* hw/rtl/rpn_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rpn_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               busy,
    output logic signed [31:0] quotient
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    // Control counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    // Restoring shift-subtract step
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        shifted  = {rem_reg, quo_reg[31]};
        trial    = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend[31] ? 32'(-dividend) : dividend;
            dsr_next = divisor[31] ? 32'(-divisor) : divisor;
            neg_next = dividend[31] ^ divisor[31];
            cnt_next = 6'd32;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = neg_reg ? 32'(-quo_reg) : quo_reg;
endmodule

/* hw/rtl/rpn_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_datapath
// Stack memory, operand registers, ALU, divider and output register.
// ----------------------------------------------------------------------------
module rpn_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  rpn_pkg::cmd_t      cmd,
    input  logic signed [31:0] push_value,
    output rpn_pkg::stat_t     stat,
    output logic               out_valid,
    input  logic               out_stall,
    output rpn_pkg::out_item_t out_item
);
    logic [31:0] mem [rpn_pkg::StackDepth];
    logic [31:0] rd_data_reg;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] res_reg;
    logic [31:0] alu;
    logic [31:0] quo;
    logic        div_busy;
    logic        ov_reg, ov_next;
    rpn_pkg::out_item_t item_reg;

    // Stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_sel_b ? b_reg : res_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    // Operand capture
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (cmd.load_a)   a_next = rd_data_reg;
        if (cmd.load_cmd) a_next = push_value;
        if (cmd.load_b)   b_next = rd_data_reg;
    end

    // ALU
    always_comb
    begin
        case (cmd.op)
            rpn_pkg::OP_ADD:  alu = b_reg + a_reg;
            rpn_pkg::OP_SUB:  alu = b_reg - a_reg;
            rpn_pkg::OP_MUL:  alu = 32'(a_reg * b_reg);
            rpn_pkg::OP_NEG:  alu = 32'(-a_reg);
            default:          alu = a_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (cmd.alu_go)
        begin
            res_reg <= alu;
        end
        else if (!div_busy && cmd.op == rpn_pkg::OP_PASS && !cmd.load_cmd
                 && !cmd.wr_en && !cmd.load_a)
        begin
            res_reg <= quo;
        end
        else if (cmd.load_cmd)
        begin
            res_reg <= push_value;
        end
        if (cmd.out_load)
        begin
            item_reg.status    <= cmd.out_status;
            item_reg.has_value <= cmd.out_has;
            item_reg.value_res <= cmd.out_from_rd ? rd_data_reg : 32'd0;
            item_reg.last      <= cmd.out_last;
        end
    end

    // Output valid
    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && !out_stall) ov_next = 1'b0;
        if (cmd.out_load)         ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (b_reg),
        .divisor  (a_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign stat = '{div_busy: div_busy,
                    a_zero:   (a_reg == 32'd0),
                    out_full: (ov_reg && out_stall)};
    assign out_valid = ov_reg;
    assign out_item  = item_reg;
endmodule

/* hw/rtl/rpn_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ctrl
// Command sequencer: owns the stack count and steers the datapath.
// ----------------------------------------------------------------------------
module rpn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [3:0]        kind,
    input  rpn_pkg::stat_t    stat,
    output rpn_pkg::cmd_t     cmd
);
    localparam int PW = rpn_pkg::PtrW;
    localparam int CW = rpn_pkg::CntW;
    localparam logic [CW-1:0] Full = CW'(rpn_pkg::StackDepth);

    rpn_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [3:0]      kind_reg, kind_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [1:0]      est_reg, est_next;
    logic            div_wait_reg, div_wait_next;
    logic            accept;
    logic [CW-1:0]   top, sec;

    assign top    = cnt_reg - CW'(1);
    assign sec    = cnt_reg - CW'(2);
    assign accept = in_valid && !in_stall;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rpn_pkg::S_IDLE;
            cnt_reg      <= '0;
            kind_reg     <= '0;
            idx_reg      <= '0;
            est_reg      <= '0;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            kind_reg     <= kind_next;
            idx_reg      <= idx_next;
            est_reg      <= est_next;
            div_wait_reg <= div_wait_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        est_next      = est_reg;
        div_wait_next = div_wait_reg;
        in_stall      = 1'b1;
        cmd           = '0;
        cmd.op        = rpn_pkg::OP_PASS;
        cmd.load_a    = 1'b0;
        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    kind_next = kind;
                    case (kind)
                        rpn_pkg::K_PUSH:
                        begin
                            if (cnt_reg >= Full)
                            begin
                                est_next   = rpn_pkg::ST_FULL;
                                state_next = rpn_pkg::S_EMIT;
                            end
                            else
                            begin
                                cmd.load_cmd = 1'b1;
                                state_next   = rpn_pkg::S_WR1;
                            end
                        end
                        rpn_pkg::K_ADD, rpn_pkg::K_SUB, rpn_pkg::K_MUL, rpn_pkg::K_DIV,
                        rpn_pkg::K_SWAP:
                        begin
                            if (cnt_reg < CW'(2))
                            begin
                                est_next   = rpn_pkg::ST_FEW;
                                state_next = rpn_pkg::S_EMIT;
                            end
                            else
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_addr = top[PW-1:0];
                                state_next  = rpn_pkg::S_RD1;
                            end
                        end
                        rpn_pkg::K_NEG, rpn_pkg::K_DUP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                est_next   = rpn_pkg::ST_FEW;
                                state_next = rpn_pkg::S_EMIT;
                            end
                            else if (kind == rpn_pkg::K_DUP && cnt_reg >= Full)
                            begin
                                est_next   = rpn_pkg::ST_FULL;
                                state_next = rpn_pkg::S_EMIT;
                            end
                            else
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_addr = top[PW-1:0];
                                state_next  = rpn_pkg::S_RD2;
                            end
                        end
                        rpn_pkg::K_CLEAR: cnt_next = '0;
                        rpn_pkg::K_PALL, rpn_pkg::K_PTOP:
                        begin
                            est_next = rpn_pkg::ST_OK;
                            if (cnt_reg == '0)
                            begin
                                state_next = rpn_pkg::S_EMIT;
                            end
                            else
                            begin
                                idx_next    = top;
                                cmd.rd_en   = 1'b1;
                                cmd.rd_addr = top[PW-1:0];
                                state_next  = rpn_pkg::S_PRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Top arrived; fetch second
            rpn_pkg::S_RD1:
            begin
                cmd.load_a  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = sec[PW-1:0];
                state_next  = rpn_pkg::S_RD2;
            end
            // Last operand arrived
            rpn_pkg::S_RD2:
            begin
                if (kind_reg inside {rpn_pkg::K_NEG, rpn_pkg::K_DUP})
                begin
                    cmd.load_a = 1'b1;
                end
                else
                begin
                    cmd.load_b = 1'b1;
                end
                state_next = rpn_pkg::S_EXEC;
            end
            rpn_pkg::S_EXEC:
            begin
                state_next = rpn_pkg::S_WR1;
                cmd.alu_go = 1'b1;
                case (kind_reg)
                    rpn_pkg::K_ADD: cmd.op = rpn_pkg::OP_ADD;
                    rpn_pkg::K_SUB: cmd.op = rpn_pkg::OP_SUB;
                    rpn_pkg::K_MUL: cmd.op = rpn_pkg::OP_MUL;
                    rpn_pkg::K_NEG: cmd.op = rpn_pkg::OP_NEG;
                    rpn_pkg::K_DIV:
                    begin
                        cmd.alu_go = 1'b0;
                        if (stat.a_zero)
                        begin
                            est_next   = rpn_pkg::ST_DIVZERO;
                            state_next = rpn_pkg::S_EMIT;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = rpn_pkg::S_DIV;
                        end
                    end
                    default: cmd.op = rpn_pkg::OP_PASS;
                endcase
            end
            // Wait for quotient; result register tracks it when idle
            rpn_pkg::S_DIV:
            begin
                cmd.op = rpn_pkg::OP_PASS;
                if (!stat.div_busy && div_wait_reg)
                begin
                    div_wait_next = 1'b0;
                    state_next    = rpn_pkg::S_WR1;
                end
                else if (!stat.div_busy)
                begin
                    div_wait_next = 1'b1;
                end
            end
            // Write back result; push, dup and binary operations also update count
            rpn_pkg::S_WR1:
            begin
                cmd.wr_en = 1'b1;
                state_next = rpn_pkg::S_IDLE;
                case (kind_reg)
                    rpn_pkg::K_PUSH, rpn_pkg::K_DUP:
                    begin
                        cmd.wr_addr = cnt_reg[PW-1:0];
                        cnt_next    = cnt_reg + CW'(1);
                    end
                    rpn_pkg::K_NEG:
                    begin
                        cmd.wr_addr = top[PW-1:0];
                    end
                    rpn_pkg::K_SWAP:
                    begin
                        cmd.wr_addr  = top[PW-1:0];
                        cmd.wr_sel_b = 1'b1;
                        state_next   = rpn_pkg::S_WR2;
                    end
                    default:
                    begin
                        cmd.wr_addr = sec[PW-1:0];
                        cnt_next    = cnt_reg - CW'(1);
                    end
                endcase
            end
            // Swap: old top goes under
            rpn_pkg::S_WR2:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = sec[PW-1:0];
                state_next  = rpn_pkg::S_IDLE;
            end
            // Present one printed element
            rpn_pkg::S_PRD:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_has     = 1'b1;
                    cmd.out_from_rd = 1'b1;
                    cmd.out_status  = rpn_pkg::ST_OK;
                    cmd.out_last    = (idx_reg == '0) || (kind_reg == rpn_pkg::K_PTOP);
                    if (cmd.out_last)
                    begin
                        state_next = rpn_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next    = idx_reg - CW'(1);
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = idx_next[PW-1:0];
                    end
                end
            end
            rpn_pkg::S_EMIT:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = est_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = rpn_pkg::S_IDLE;
                end
            end
            default: state_next = rpn_pkg::S_IDLE;
        endcase
    end
endmodule

/* hw/rtl/rpn_stack_calculator.sv */
`timescale 1ns / 1ps
// Commands are taken one at a time: the next is accepted only after the previous one finishes.
// The divider is a 32-step restoring shift-subtract loop; print-all walks the stack top down.
// Reset: async active low empties the stack and clears the output valid flag.
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse-Polish calculator over a 16-entry stack of 32-bit signed values.
// ----------------------------------------------------------------------------
module rpn_stack_calculator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rpn_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output rpn_pkg::out_item_t out_item
);
    rpn_pkg::cmd_t  cmd;
    rpn_pkg::stat_t stat;

    rpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (in_item.kind),
        .stat     (stat),
        .cmd      (cmd)
    );

    rpn_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_value (in_item.value),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );
endmodule

/* hw/rtl/rpn_checker.sv */
`timescale 1ns / 1ps
`include "rpn_stack_calculator_defines.svh"
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks on the calculator's handshakes and error items.
// ----------------------------------------------------------------------------
module rpn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input rpn_pkg::out_item_t out_item
);
    `RPN_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_item), "output moved")
    `RPN_ASSERT(a_err_last, clk, rst_n, out_valid && out_item.status != rpn_pkg::ST_OK |-> out_item.last && !out_item.has_value, "bad error")
    `RPN_KNOWN(a_valid_known, clk, rst_n, in_valid, "input valid unknown")
    `RPN_KNOWN(a_stall_known, clk, rst_n, in_stall, "input stall unknown")
endmodule

bind rpn_stack_calculator rpn_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

/* sim/rpn_stack_calculator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_checker
// Watches both channels of the calculator, keeps its own copy of the stack,
// predicts the results of every accepted command and compares them in order.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  rpn_pkg::in_item_t  in_item,
    input  logic               out_valid,
    input  logic               out_stall,
    input  rpn_pkg::out_item_t out_item,
    output int                 fail_count,
    output int                 pending
);

    logic [31:0]        stack_mirror [rpn_pkg::StackDepth];
    int                 depth_mirror;
    rpn_pkg::out_item_t expected_results [$];

    assign pending = expected_results.size();

    // Queue one result item
    function automatic void queue_result(rpn_pkg::status_t st, logic has, logic [31:0] v,
                                         logic lst);
        rpn_pkg::out_item_t r;
        r.status    = st;
        r.has_value = has;
        r.value_res = v;
        r.last      = lst;
        expected_results.push_back(r);
    endfunction

    // Advance the mirrored stack by one command and queue its results
    function automatic void apply_command(rpn_pkg::in_item_t cmd);
        logic [31:0] top, second, res;
        int n;
        n = depth_mirror;
        case (cmd.kind)
            rpn_pkg::K_PUSH:
                if (n >= rpn_pkg::StackDepth) queue_result(rpn_pkg::ST_FULL, 1'b0, '0, 1'b1);
                else
                begin
                    stack_mirror[n] = cmd.value;
                    depth_mirror = n + 1;
                end
            rpn_pkg::K_ADD, rpn_pkg::K_SUB, rpn_pkg::K_MUL, rpn_pkg::K_DIV, rpn_pkg::K_SWAP:
                if (n < 2) queue_result(rpn_pkg::ST_FEW, 1'b0, '0, 1'b1);
                else
                begin
                    top    = stack_mirror[n-1];
                    second = stack_mirror[n-2];
                    if (cmd.kind == rpn_pkg::K_SWAP)
                    begin
                        stack_mirror[n-1] = second;
                        stack_mirror[n-2] = top;
                    end
                    else if (cmd.kind == rpn_pkg::K_DIV && top == 0)
                        queue_result(rpn_pkg::ST_DIVZERO, 1'b0, '0, 1'b1);
                    else
                    begin
                        case (cmd.kind)
                            rpn_pkg::K_ADD:   res = second + top;
                            rpn_pkg::K_SUB:   res = second - top;
                            rpn_pkg::K_MUL:   res = second * top;
                            default:
                                // most negative over -1 wraps to itself
                                if (second == 32'h8000_0000 && top == 32'hffff_ffff)
                                    res = second;
                                else
                                    res = $signed(second) / $signed(top);
                        endcase
                        stack_mirror[n-2] = res;
                        depth_mirror = n - 1;
                    end
                end
            rpn_pkg::K_NEG:
                if (n < 1) queue_result(rpn_pkg::ST_FEW, 1'b0, '0, 1'b1);
                else stack_mirror[n-1] = -stack_mirror[n-1];
            rpn_pkg::K_DUP:
                if (n < 1) queue_result(rpn_pkg::ST_FEW, 1'b0, '0, 1'b1);
                else if (n >= rpn_pkg::StackDepth)
                    queue_result(rpn_pkg::ST_FULL, 1'b0, '0, 1'b1);
                else
                begin
                    stack_mirror[n] = stack_mirror[n-1];
                    depth_mirror = n + 1;
                end
            rpn_pkg::K_CLEAR:
                depth_mirror = 0;
            rpn_pkg::K_PALL:
                if (n == 0) queue_result(rpn_pkg::ST_OK, 1'b0, '0, 1'b1);
                else
                    for (int k = 0; k < n; k++)
                        queue_result(rpn_pkg::ST_OK, 1'b1, stack_mirror[n-1-k], k == n - 1);
            rpn_pkg::K_PTOP:
                if (n == 0) queue_result(rpn_pkg::ST_OK, 1'b0, '0, 1'b1);
                else queue_result(rpn_pkg::ST_OK, 1'b1, stack_mirror[n-1], 1'b1);
            default:
                ;
        endcase
    endfunction

    // Predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        rpn_pkg::out_item_t want;
        if (!rst_n)
        begin
            depth_mirror = 0;
            fail_count   = 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_command(in_item);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_item);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status != out_item.status
                        || want.has_value != out_item.has_value
                        || want.value_res != out_item.value_res
                        || want.last != out_item.last)
                    begin
                        $display({"%0t: mismatch expected st=%0d has=%0d val=%h last=%0d,",
                                  " actual st=%0d has=%0d val=%h last=%0d"},
                                 $time, want.status, want.has_value, want.value_res,
                                 want.last, out_item.status, out_item.has_value,
                                 out_item.value_res, out_item.last);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* sim/tb_rpn_stack_calculator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_stack_calculator
// Drives directed and random command streams into the calculator with random
// gaps and output stalls, including one long stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_rpn_stack_calculator;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    rpn_pkg::in_item_t  in_item = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    rpn_pkg::out_item_t out_item;
    int                 fail_count;
    int                 pending;
    bit                 long_hold_done = 1'b0;

    always #5 clk = ~clk;

    rpn_stack_calculator dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
        .out_item(out_item)
    );

    rpn_stack_calculator_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
        .out_item(out_item), .fail_count(fail_count), .pending(pending)
    );

    // Offer one command after a random gap and hold it until it transfers
    task automatic send_command(logic [3:0] k, logic [31:0] v);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {k, v};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off partway through
    initial
    begin
        int wait_cycles;
        int transfers;
        transfers = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall) transfers++;
            if (!long_hold_done && transfers == 30)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                long_hold_done = 1'b1;
                out_stall <= 1'b0;
            end
            else
            begin
                wait_cycles = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
                if (wait_cycles > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty stack errors and prints, then arithmetic corner cases
        send_command(rpn_pkg::K_PALL, 0);
        send_command(rpn_pkg::K_PTOP, 0);
        send_command(rpn_pkg::K_ADD, 0);
        send_command(rpn_pkg::K_NEG, 0);
        send_command(rpn_pkg::K_DUP, 0);
        send_command(rpn_pkg::K_PUSH, 32'h8000_0000);
        send_command(rpn_pkg::K_SWAP, 0);
        send_command(rpn_pkg::K_PUSH, 32'hffff_ffff);
        send_command(rpn_pkg::K_DIV, 0);           // wraps to the most negative value
        send_command(rpn_pkg::K_PUSH, 32'h7fff_ffff);
        send_command(rpn_pkg::K_PUSH, 0);
        send_command(rpn_pkg::K_DIV, 0);           // divide by zero
        send_command(rpn_pkg::K_PUSH, -7);
        send_command(rpn_pkg::K_DIV, 0);
        send_command(rpn_pkg::K_PUSH, 3);
        send_command(rpn_pkg::K_SUB, 0);
        send_command(rpn_pkg::K_PUSH, 32'h7fff_ffff);
        send_command(rpn_pkg::K_MUL, 0);
        send_command(rpn_pkg::K_ADD, 0);
        send_command(rpn_pkg::K_NEG, 0);
        send_command(4'd11, 0);
        send_command(4'd15, 0);
        send_command(rpn_pkg::K_PALL, 0);
        send_command(rpn_pkg::K_CLEAR, 0);
        send_command(rpn_pkg::K_PTOP, 0);

        // Random: fill toward full, mixed with arithmetic and prints
        for (int i = 0; i < 7; i++)
        begin
            len = $urandom_range(1, 18);
            for (int j = 0; j < len; j++)
                send_command(($urandom_range(0, 2) == 0) ? rpn_pkg::K_DUP : rpn_pkg::K_PUSH,
                             pick_value());
            for (int j = 0; j < 4; j++)
                send_command(4'($urandom_range(0, 15)), pick_value());
            send_command(rpn_pkg::K_PALL, 0);
            if ($urandom_range(0, 1)) send_command(rpn_pkg::K_CLEAR, 0);
        end
        in_valid <= 1'b0;

        fork
        begin
            while (pending != 0 || !long_hold_done) @(posedge clk);
            repeat (60) @(posedge clk);
        end
        begin
            repeat (200000) @(posedge clk);
        end
        join_any
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
